### sv/lkvc_pkg.sv
// Shared types and constants for the LRU key/value cache.
// Used by lkvc_cell and lru_key_value_cache; no dependencies.
package lkvc_pkg;

	localparam int DEPTH  = 16;
	localparam int RANK_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int KEY_W  = 64;
	localparam int VAL_W  = 32;

	typedef enum logic [2:0] {
		OP_GET    = 3'd0,
		OP_PUT    = 3'd1,
		OP_HAS    = 3'd2,
		OP_REMOVE = 3'd3,
		OP_CLEAR  = 3'd4,
		OP_FLUSH  = 3'd5,
		OP_STATS  = 3'd6
	} op_t;

	typedef enum logic [1:0] {
		KIND_RESP  = 2'd0,
		KIND_EVICT = 2'd1,
		KIND_FLUSH = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		CMD_NONE   = 3'd0,
		CMD_TOUCH  = 3'd1,
		CMD_WRITE  = 3'd2,
		CMD_DROP   = 3'd3,
		CMD_INSERT = 3'd4,
		CMD_CLEAR  = 3'd5
	} cmd_kind_t;

	// Selects which cell drives the chain: by key or by recency rank.
	typedef struct packed {
		logic              by_rank;
		logic [RANK_W-1:0] rank;
		logic [KEY_W-1:0]  key;
	} query_t;

	// Update broadcast to every cell at the clock edge.
	typedef struct packed {
		cmd_kind_t         kind;
		logic [RANK_W-1:0] rank;
		logic [VAL_W-1:0]  value;
	} cmd_t;

	// Data handed from one cell to the next.
	typedef struct packed {
		logic              found;
		logic              free_seen;
		logic [RANK_W-1:0] rank;
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  value;
	} link_t;

endpackage

### sv/lkvc_cell.sv
// One cache entry: key, value, valid bit and recency rank.
// Depends on lkvc_pkg; chained by lru_key_value_cache.
module lkvc_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  lkvc_pkg::query_t query,
	input  lkvc_pkg::cmd_t   cmd,
	input  lkvc_pkg::link_t  link_in,
	output lkvc_pkg::link_t  link_out,
	output logic             sel
);
	import lkvc_pkg::*;

	logic              valid_q;
	logic [RANK_W-1:0] rank_q;
	logic [KEY_W-1:0]  key_q;
	logic [VAL_W-1:0]  value_q;
	logic              first_free;

	assign sel = valid_q && (query.by_rank ? (rank_q == query.rank) : (key_q == query.key));
	// The lowest free cell is the one with no free cell before it.
	assign first_free = !valid_q && !link_in.free_seen;

	always_comb begin
		link_out.found     = link_in.found | sel;
		link_out.free_seen = link_in.free_seen | !valid_q;
		link_out.rank      = link_in.rank | (sel ? rank_q : '0);
		link_out.key       = link_in.key | (sel ? key_q : '0);
		link_out.value     = link_in.value | (sel ? value_q : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else begin
			unique case (cmd.kind)
				CMD_TOUCH, CMD_WRITE: begin
					if (sel) begin
						rank_q <= '0;
					end else if (valid_q && rank_q < cmd.rank) begin
						rank_q <= rank_q + 1'b1;
					end
				end
				CMD_DROP: begin
					if (sel) begin
						valid_q <= 1'b0;
						rank_q  <= '0;
					end else if (valid_q && rank_q > cmd.rank) begin
						rank_q <= rank_q - 1'b1;
					end
				end
				CMD_INSERT: begin
					if (first_free) begin
						valid_q <= 1'b1;
						rank_q  <= '0;
					end else if (valid_q) begin
						rank_q <= rank_q + 1'b1;
					end
				end
				CMD_CLEAR: begin
					valid_q <= 1'b0;
					rank_q  <= '0;
				end
				CMD_NONE: ;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.kind == CMD_WRITE && sel) begin
			value_q <= cmd.value;
		end
		if (cmd.kind == CMD_INSERT && first_free) begin
			key_q   <= query.key;
			value_q <= cmd.value;
		end
	end

endmodule

### sv/lru_key_value_cache.sv
// Top level of the fully associative LRU key/value cache.
// Depends on lkvc_pkg and lkvc_cell.
//
// A fully associative cache of DEPTH entries built as a row of cells, each
// holding one key, value, valid bit and recency rank. A lookup broadcasts the
// key to all cells at once; the matching cell places its contents on a chain
// that runs from cell to cell, and an update command is broadcast back in the
// same cycle. Get, has, remove, reset stats and a put that hits or finds room
// are captured and then looked up; the lookup emits the response. A put that
// has to evict emits an eviction record before its response. Clear and flush
// walk the entries by rank, one record per cycle over the single chain while
// the result side is ready, and close with a final response. Every
// item ends in one response with last set; records before it have last clear.
// The next item is taken once the response is in the output register, so a
// waiting result does not block the input side. Capacity is written through
// its own channel only while the block is idle; zero acts as one and values
// above the depth act as the depth.
module lru_key_value_cache (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  op,
	input  logic [63:0] key,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic        hit,
	output logic [63:0] out_key,
	output logic [31:0] out_value,
	output logic [4:0]  occupancy,
	output logic [63:0] hit_count,
	output logic [63:0] miss_count,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data
);
	import lkvc_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_LOOK   = 6'b000010,
		S_EVICT  = 6'b000100,
		S_INSERT = 6'b001000,
		S_SCAN   = 6'b010000,
		S_FIN    = 6'b100000
	} state_t;

	state_t            state_q, state_d;
	logic [2:0]        op_q;
	logic [KEY_W-1:0]  key_q;
	logic [VAL_W-1:0]  val_q;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CNT_W-1:0]  scan_q, scan_d;
	logic [63:0]       hits_q, hits_d, misses_q, misses_d;
	logic [4:0]        cap_q;
	logic [CNT_W-1:0]  cap_eff;

	query_t            query;
	cmd_t              cmd;
	link_t             links [DEPTH+1];
	link_t             bus;
	logic [DEPTH-1:0]  sel_vec;

	logic              out_free, emit, is_clear;
	kind_t             e_kind;
	logic              e_hit, e_last;
	logic [KEY_W-1:0]  e_key;
	logic [VAL_W-1:0]  e_val;
	logic [CNT_W-1:0]  e_occ;

	logic              out_valid_q;
	kind_t             kind_q;
	logic              hit_q, last_q;
	logic [KEY_W-1:0]  okey_q;
	logic [VAL_W-1:0]  oval_q;
	logic [CNT_W-1:0]  occ_q;
	logic [63:0]       ohits_q, omisses_q;

	// The chain of entries: each cell ORs its contents onto the link when selected.
	assign links[0] = '0;
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		lkvc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.query   (query),
			.cmd     (cmd),
			.link_in (links[i]),
			.link_out(links[i+1]),
			.sel     (sel_vec[i])
		);
	end
	assign bus = links[DEPTH];

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign out_free  = !out_valid_q || out_ready;
	assign is_clear  = (op_q == OP_CLEAR);

	always_comb begin
		if (cap_q == 5'd0) begin
			cap_eff = CNT_W'(1);
		end else if (cap_q > 5'(DEPTH)) begin
			cap_eff = CNT_W'(DEPTH);
		end else begin
			cap_eff = CNT_W'(cap_q);
		end
	end

	always_comb begin
		state_d       = state_q;
		count_d       = count_q;
		scan_d        = scan_q;
		hits_d        = hits_q;
		misses_d      = misses_q;
		query.by_rank = 1'b0;
		query.rank    = '0;
		query.key     = key_q;
		cmd.kind      = CMD_NONE;
		cmd.rank      = bus.rank;
		cmd.value     = val_q;
		emit          = 1'b0;
		e_kind        = KIND_RESP;
		e_hit         = 1'b0;
		e_key         = key_q;
		e_val         = '0;
		e_last        = 1'b1;
		e_occ         = count_q;

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_LOOK;
				end
			end
			S_LOOK: begin
				if (out_free) begin
					unique case (op_t'(op_q))
						OP_GET: begin
							emit    = 1'b1;
							state_d = S_IDLE;
							if (bus.found) begin
								cmd.kind = CMD_TOUCH;
								hits_d   = hits_q + 64'd1;
								e_hit    = 1'b1;
								e_val    = bus.value;
							end else begin
								misses_d = misses_q + 64'd1;
							end
						end
						OP_PUT: begin
							if (bus.found) begin
								cmd.kind = CMD_WRITE;
								e_hit    = 1'b1;
								emit     = 1'b1;
								state_d  = S_IDLE;
							end else if (count_q >= cap_eff && count_q != '0) begin
								state_d = S_EVICT;
							end else begin
								cmd.kind = CMD_INSERT;
								count_d  = count_q + 1'b1;
								emit     = 1'b1;
								state_d  = S_IDLE;
							end
						end
						OP_HAS: begin
							e_hit   = bus.found;
							emit    = 1'b1;
							state_d = S_IDLE;
						end
						OP_REMOVE: begin
							if (bus.found) begin
								cmd.kind = CMD_DROP;
								count_d  = count_q - 1'b1;
								e_hit    = 1'b1;
							end
							emit    = 1'b1;
							state_d = S_IDLE;
						end
						OP_CLEAR, OP_FLUSH: begin
							if (count_q == '0) begin
								emit    = 1'b1;
								state_d = S_IDLE;
							end else begin
								scan_d  = '0;
								state_d = S_SCAN;
							end
						end
						OP_STATS: begin
							hits_d   = '0;
							misses_d = '0;
							emit     = 1'b1;
							state_d  = S_IDLE;
						end
						default: begin
							emit    = 1'b1;
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_EVICT: begin
				// The least recent entry holds rank occupancy - 1.
				query.by_rank = 1'b1;
				query.rank    = RANK_W'(count_q - 1'b1);
				if (out_free) begin
					cmd.kind = CMD_DROP;
					count_d  = count_q - 1'b1;
					emit     = 1'b1;
					e_kind   = KIND_EVICT;
					e_key    = bus.key;
					e_val    = bus.value;
					e_last   = 1'b0;
					state_d  = S_INSERT;
				end
			end
			S_INSERT: begin
				if (out_free) begin
					cmd.kind = CMD_INSERT;
					count_d  = count_q + 1'b1;
					emit     = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_SCAN: begin
				query.by_rank = 1'b1;
				query.rank    = scan_q[RANK_W-1:0];
				if (out_free) begin
					emit   = 1'b1;
					e_kind = is_clear ? KIND_EVICT : KIND_FLUSH;
					e_key  = bus.key;
					e_val  = bus.value;
					e_last = 1'b0;
					e_occ  = is_clear ? '0 : count_q;
					scan_d = scan_q + 1'b1;
					if (scan_d == count_q) begin
						state_d = S_FIN;
					end
				end
			end
			S_FIN: begin
				if (out_free) begin
					if (is_clear) begin
						cmd.kind = CMD_CLEAR;
						count_d  = '0;
					end
					emit    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// A response reports the state after the whole operation.
		if (e_kind == KIND_RESP) begin
			e_occ = count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			scan_q      <= '0;
			hits_q      <= '0;
			misses_q    <= '0;
			cap_q       <= 5'd16;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			scan_q   <= scan_d;
			hits_q   <= hits_d;
			misses_q <= misses_d;
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q  <= op;
			key_q <= key;
			val_q <= value;
		end
		if (emit) begin
			kind_q    <= e_kind;
			hit_q     <= e_hit;
			okey_q    <= e_key;
			oval_q    <= e_val;
			occ_q     <= e_occ;
			ohits_q   <= hits_d;
			omisses_q <= misses_d;
			last_q    <= e_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign hit        = hit_q;
	assign out_key    = okey_q;
	assign out_value  = oval_q;
	assign occupancy  = 5'(occ_q);
	assign hit_count  = ohits_q;
	assign miss_count = omisses_q;
	assign last       = last_q;

	// Keys are unique among valid entries, so a key lookup selects at most one cell.
	a_key_unique: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOOK) |-> $onehot0(sel_vec))
		else $error("more than one cell matched the key");

	// Ranks of valid entries are a permutation, so a rank lookup finds exactly one.
	a_rank_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EVICT || state_q == S_SCAN) |-> $onehot(sel_vec))
		else $error("rank lookup did not select exactly one cell");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("occupancy exceeds depth");

	a_accept_look: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_LOOK))
		else $error("accepted item was not looked up");

endmodule

### bench/tb_cache_checker.sv
// Scoreboard for the LRU key/value cache: watches the request, result and
// capacity channels, runs its own cache model and compares every result.
// Depends on lkvc_pkg.
module tb_cache_checker
	import lkvc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [2:0]  op,
	input  logic [63:0] key,
	input  logic [31:0] value,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  kind,
	input  logic        hit,
	input  logic [63:0] out_key,
	input  logic [31:0] out_value,
	input  logic [4:0]  occupancy,
	input  logic [63:0] hit_count,
	input  logic [63:0] miss_count,
	input  logic        last,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [4:0]  cfg_data,
	output int          errors,
	output int          pending
);

	typedef struct packed {
		logic [1:0]  kind;
		logic        hit;
		logic [63:0] key;
		logic [31:0] value;
		logic [4:0]  occ;
		logic [63:0] hits;
		logic [63:0] misses;
		logic        last;
	} rec_t;

	rec_t        expected_q[$];
	logic [63:0] slot_key[DEPTH];
	logic [31:0] slot_val[DEPTH];
	logic        slot_on[DEPTH];
	int          slot_rank[DEPTH];
	int          used;
	logic [63:0] n_hits, n_misses;
	int          cap_reg;

	function automatic int slot_of_key(logic [63:0] k);
		for (int i = 0; i < DEPTH; i++)
			if (slot_on[i] && slot_key[i] == k) return i;
		return -1;
	endfunction

	function automatic int slot_of_rank(int r);
		for (int i = 0; i < DEPTH; i++)
			if (slot_on[i] && slot_rank[i] == r) return i;
		return -1;
	endfunction

	function automatic void make_recent(int s);
		for (int i = 0; i < DEPTH; i++)
			if (i != s && slot_on[i] && slot_rank[i] < slot_rank[s]) slot_rank[i]++;
		slot_rank[s] = 0;
	endfunction

	function automatic void vacate(int s);
		for (int i = 0; i < DEPTH; i++)
			if (i != s && slot_on[i] && slot_rank[i] > slot_rank[s]) slot_rank[i]--;
		slot_on[s] = 0;
		slot_rank[s] = 0;
		if (used > 0) used--;
	endfunction

	// Works out every result of one request, records first, response last.
	function automatic void predict_cache_op(logic [2:0] o, logic [63:0] k, logic [31:0] v);
		rec_t recs[$];
		rec_t r;
		int s, cap, lru;
		logic h;
		logic [31:0] rv;
		h = 0;
		rv = '0;
		case (o)
			OP_GET: begin
				s = slot_of_key(k);
				if (s >= 0) begin
					h = 1;
					rv = slot_val[s];
					n_hits++;
					make_recent(s);
				end else n_misses++;
			end
			OP_PUT: begin
				s = slot_of_key(k);
				if (s >= 0) begin
					h = 1;
					slot_val[s] = v;
					make_recent(s);
				end else begin
					cap = cap_reg < 1 ? 1 : (cap_reg > DEPTH ? DEPTH : cap_reg);
					if (used >= cap && used > 0) begin
						lru = slot_of_rank(used - 1);
						if (lru >= 0) begin
							r = '0;
							r.kind = KIND_EVICT;
							r.key = slot_key[lru];
							r.value = slot_val[lru];
							recs.push_back(r);
							vacate(lru);
						end
					end
					s = slot_of_key(64'h0) >= 0 ? -1 : -1;
					for (int i = 0; i < DEPTH; i++)
						if (!slot_on[i] && s < 0) s = i;
					if (s >= 0) begin
						for (int i = 0; i < DEPTH; i++)
							if (slot_on[i]) slot_rank[i]++;
						slot_key[s] = k;
						slot_val[s] = v;
						slot_on[s] = 1;
						slot_rank[s] = 0;
						used++;
					end
				end
			end
			OP_HAS: h = slot_of_key(k) >= 0;
			OP_REMOVE: begin
				s = slot_of_key(k);
				if (s >= 0) begin
					h = 1;
					vacate(s);
				end
			end
			OP_CLEAR, OP_FLUSH: begin
				for (int q = 0; q < used && q < DEPTH; q++) begin
					s = slot_of_rank(q);
					if (s >= 0) begin
						r = '0;
						r.kind = (o == OP_CLEAR) ? KIND_EVICT : KIND_FLUSH;
						r.key = slot_key[s];
						r.value = slot_val[s];
						recs.push_back(r);
					end
				end
				if (o == OP_CLEAR) begin
					for (int i = 0; i < DEPTH; i++) begin
						slot_on[i] = 0;
						slot_rank[i] = 0;
					end
					used = 0;
				end
			end
			OP_STATS: begin
				n_hits = '0;
				n_misses = '0;
			end
			default: ;
		endcase
		r = '0;
		r.kind = KIND_RESP;
		r.hit = h;
		r.key = k;
		r.value = rv;
		recs.push_back(r);
		foreach (recs[i]) begin
			recs[i].occ = used[4:0];
			recs[i].hits = n_hits;
			recs[i].misses = n_misses;
			recs[i].last = (i == recs.size() - 1);
			expected_q.push_back(recs[i]);
		end
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		rec_t got, want;
		if (!arst_n) begin
			expected_q.delete();
			for (int i = 0; i < DEPTH; i++) begin
				slot_on[i] = 0;
				slot_rank[i] = 0;
			end
			used = 0;
			n_hits = '0;
			n_misses = '0;
			cap_reg = 16;
			errors = 0;
		end else begin
			if (cfg_valid && cfg_ready) cap_reg = cfg_data;
			// Results are checked before the model advances, since a request may
			// be accepted on the same edge as the previous item's response.
			if (out_valid && out_ready) begin
				got = {kind, hit, out_key, out_value, occupancy, hit_count,
					miss_count, last};
				if (expected_q.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected result %h", got);
				end else begin
					want = expected_q.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected kind %0d hit %0d key %h val %h occ %0d hits %0d misses %0d last %0d; got kind %0d hit %0d key %h val %h occ %0d hits %0d misses %0d last %0d",
								want.kind, want.hit, want.key, want.value, want.occ,
								want.hits, want.misses, want.last, got.kind, got.hit,
								got.key, got.value, got.occ, got.hits, got.misses,
								got.last);
					end
				end
			end
			if (in_valid && in_ready) predict_cache_op(op, key, value);
		end
	end

endmodule

### bench/tb_top.sv
// Top of the cache testbench: clock, reset, request and capacity stimulus,
// and the verdict. Depends on lkvc_pkg, lru_key_value_cache, tb_cache_checker.
module tb_top;
	import lkvc_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  op;
	logic [63:0] key;
	logic [31:0] value;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  kind;
	logic        hit;
	logic [63:0] out_key;
	logic [31:0] out_value;
	logic [4:0]  occupancy;
	logic [63:0] hit_count;
	logic [63:0] miss_count;
	logic        last;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [4:0]  cfg_data;
	int          errors;
	int          pending;
	int          cycles;

	// Keys are drawn from a small pool so that gets, removes and puts hit
	// often; a few fully random keys keep every key bit moving.
	logic [63:0] key_pool[24];

	lru_key_value_cache dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .key(key), .value(value),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .hit(hit), .out_key(out_key), .out_value(out_value),
		.occupancy(occupancy), .hit_count(hit_count), .miss_count(miss_count),
		.last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	tb_cache_checker scoreboard (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// Watchdog. The slowest item is a clear or flush of 16 entries with
	// every record waiting out a long stall, far below this bound.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 400000) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// The result side may stall before each transfer, with
	// some stretches of no stall at all.
	initial begin
		int gap;
		out_ready = 0;
		forever begin
			@(posedge clk);
			if (out_ready && out_valid) out_ready <= 0;
			else if (!out_ready) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
				repeat (gap) @(posedge clk);
				out_ready <= 1;
			end
		end
	end

	// Valid stays high into the next request when there is no gap, so the
	// next request follows its predecessor without an idle cycle.
	task automatic send_request(logic [2:0] o, logic [63:0] k, logic [31:0] v);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		op <= o;
		key <= k;
		value <= v;
		do @(posedge clk); while (!in_ready);
	endtask

	// Drops valid and waits until every expected result is in, so that the
	// block is idle.
	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Writes capacity once every expected result is in and the longest
	// operation (clear of a full cache) has surely ended.
	task automatic set_capacity(logic [4:0] c);
		drain();
		repeat (24) @(posedge clk);
		cfg_valid <= 1;
		cfg_data <= c;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
	endtask

	task automatic random_phase(int count);
		int pick;
		logic [2:0] o;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) o = OP_GET;
			else if (pick < 65) o = OP_PUT;
			else if (pick < 75) o = OP_HAS;
			else if (pick < 87) o = OP_REMOVE;
			else if (pick < 91) o = OP_CLEAR;
			else if (pick < 95) o = OP_FLUSH;
			else if (pick < 98) o = OP_STATS;
			else o = 3'd7;
			send_request(o, ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
				: key_pool[$urandom_range(0, 23)], $urandom);
		end
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0;
		op = OP_GET;
		key = '0;
		value = '0;
		cfg_valid = 0;
		cfg_data = '0;
		foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
		key_pool[0] = '0;
		key_pool[1] = '1;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed part: extreme keys and values, every operation, a miss and
		// a hit of each lookup, eviction with capacity one, and op code 7.
		send_request(OP_GET, '0, '0);
		send_request(OP_PUT, '0, '1);
		send_request(OP_PUT, '1, '0);
		send_request(OP_GET, '0, 32'h5);
		send_request(OP_PUT, '0, 32'hA5A5_5A5A);
		send_request(OP_HAS, '1, '0);
		send_request(OP_HAS, 64'h1234, '0);
		send_request(OP_FLUSH, '0, '0);
		send_request(OP_REMOVE, '1, '0);
		send_request(OP_REMOVE, '1, '0);
		send_request(OP_STATS, '0, '0);
		send_request(3'd7, 64'hDEAD_BEEF, '1);
		send_request(OP_CLEAR, '0, '0);
		send_request(OP_CLEAR, '0, '0);
		set_capacity(5'd1);
		send_request(OP_PUT, 64'h11, 32'h1);
		send_request(OP_PUT, 64'h22, 32'h2);
		send_request(OP_GET, 64'h11, '0);
		// Zero acts as one; raise it, fill, then lower it below occupancy.
		set_capacity(5'd0);
		send_request(OP_PUT, 64'h33, 32'h3);
		set_capacity(5'd31);
		for (int i = 0; i < 6; i++) send_request(OP_PUT, key_pool[i], $urandom);
		set_capacity(5'd2);
		send_request(OP_PUT, 64'h44, 32'h4);
		send_request(OP_FLUSH, '0, '0);

		// Random phases at several capacities, the extremes among them.
		set_capacity(5'd16);
		random_phase(60);
		set_capacity(5'd3);
		random_phase(40);
		set_capacity(5'd1);
		random_phase(20);
		set_capacity(5'($urandom_range(17, 31)));
		random_phase(60);
		send_request(OP_FLUSH, '0, '0);

		drain();
		repeat (30) @(posedge clk);
		if (errors == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

endmodule

### sim.f
sv/lkvc_pkg.sv
sv/lkvc_cell.sv
sv/lru_key_value_cache.sv
bench/tb_cache_checker.sv
bench/tb_top.sv
